[rtl/pwso_pkg.sv]
package pwso_pkg;

  // phase fraction bits below the table index
  localparam int FRAC_BITS = 21;

  // voice defaults after reset
  localparam logic [31:0]        INC_RESET = 32'd42852281;
  localparam logic signed [15:0] AMP_RESET = 16'sd16384;

  // datapath widths: difference of two samples, second multiplier operand, product
  localparam int DIFF_W = 17;
  localparam int MB_W   = FRAC_BITS + 1;
  localparam int PROD_W = DIFF_W + MB_W;

  // pi in Q30 and the taylor term divisors (2n)(2n+1)
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int SINE_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_INC = 2'd1,
    OP_SET_AMP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_FM_ENABLE = 2'd0,
    REG_AM_ENABLE = 2'd1,
    REG_MONO      = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_SET_INC,
    KIND_SET_AMP
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_LOOK0,
    ST_LOOK1,
    ST_LOOK2,
    ST_MUL1,
    ST_ADD,
    ST_MUL2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic fm_enable;
    logic am_enable;
    logic mono;
  } cfg_t;

  typedef struct packed {
    logic load;      // take the input word
    logic pos_en;    // form lookup position and effective amplitude
    logic rom_en;    // read the quarter-wave table
    logic rom_sel;   // 0: left neighbor, 1: right neighbor
    logic cap_t0;    // keep left sample
    logic cap_diff;  // keep right minus left
    logic mul_en;    // load product register
    logic mul_sel;   // 0: diff * frac, 1: interp * amp
    logic add_en;    // finish interpolation
    logic out_load;  // load output word and write back phase
  } ctl_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
  } status_t;

  // quarter-wave sine in unsigned Q0.15 for entry k of a table of 2^tw entries
  function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned tw);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x   = (64'd2 * PI_Q30 * 64'(k)) >> tw;
    t   = x;
    sum = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'(SINE_DIV[n-1]);
      if (n[0]) begin
        sum = sum - signed'(t);
      end else begin
        sum = sum + signed'(t);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[14:0];
  endfunction

endpackage

[rtl/polyphonic_wavetable_sine_oscillator.sv]
// channel   direction  signals                                   word
// s_*       in         s_tvalid s_tready s_tdata[87:0] s_tuser   one command per word
// m_*       out        m_tvalid m_tready m_tdata[23:0]           one sample per tick
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// a tick holds s_tready low from acceptance until the controller has walked one
// lookup through the single-port sine table, the shared multiplier (interpolation,
// then gain) and the phase write-back, so a new command is taken only after the
// tick is through
// set commands, ignored commands and out-of-range voices never leave idle
// rst is synchronous; voice stores read as their defaults until written
// a full output register with m_tready low holds the tick in its last step
module polyphonic_wavetable_sine_oscillator
  import pwso_pkg::*;
  #(
    parameter int TABLE_SIZE = 2048,
    parameter int VOICES     = 16
  )
  (
    input  logic        clk,
    input  logic        rst,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // voice[3:0] fm_offset[35:4] am_offset[51:36]
                                   // write_value[83:52], zero pad [87:84]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // output words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample[15:0] sample_voice[19:16], zero pad [23:20]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
  );

  cfg_t    cfg;
  ctl_t    ctl;
  status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FM_ENABLE: cfg.fm_enable <= cfg_data;
        REG_AM_ENABLE: cfg.am_enable <= cfg_data;
        REG_MONO:      cfg.mono      <= cfg_data;
        default:       cfg           <= cfg;  // unmapped index, no effect
      endcase
    end
  end

  // sequencer: one tick at a time through the datapath
  pwso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .ctl      (ctl)
  );

  // voice stores, sine table, shared multiplier and output register
  pwso_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .VOICES     (VOICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .ctl       (ctl),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

[rtl/pwso_ram.sv]
module pwso_ram
  #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pwso_ctrl.sv]
module pwso_ctrl
  import pwso_pkg::*;
  (
    input  logic    clk,
    input  logic    rst,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output ctl_t    ctl
  );

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.kind == KIND_TICK) begin
          state_next = ST_POS;
        end
      end
      ST_POS:   state_next = ST_LOOK0;
      ST_LOOK0: state_next = ST_LOOK1;
      ST_LOOK1: state_next = ST_LOOK2;
      ST_LOOK2: state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_ADD;
      ST_ADD:   state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_POS: ctl.pos_en = 1'b1;
      ST_LOOK0: ctl.rom_en = 1'b1;
      ST_LOOK1: begin
        ctl.rom_en  = 1'b1;
        ctl.rom_sel = 1'b1;
        ctl.cap_t0  = 1'b1;
      end
      ST_LOOK2: ctl.cap_diff = 1'b1;
      ST_MUL1: ctl.mul_en = 1'b1;
      ST_ADD: ctl.add_en = 1'b1;
      ST_MUL2: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = 1'b1;
      end
      ST_OUT: ctl.out_load = status.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

[rtl/pwso_dp.sv]
module pwso_dp
  import pwso_pkg::*;
  #(
    parameter int TABLE_SIZE = 2048,
    parameter int VOICES     = 16
  )
  (
    input  logic        clk,
    input  logic        rst,
    input  cfg_t        cfg,
    input  logic [87:0] in_data,
    input  logic [1:0]  in_user,
    input  ctl_t        ctl,
    output status_t     status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] out_data
  );

  localparam int TW      = $clog2(TABLE_SIZE);
  localparam int PW      = TW + FRAC_BITS;
  localparam int IW      = TW + 1;
  localparam int QUARTER = TABLE_SIZE / 4;
  localparam int QAW     = TW - 1;
  localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam logic [IW-1:0] Q1 = IW'(QUARTER);
  localparam logic [IW-1:0] Q2 = IW'(2 * QUARTER);
  localparam logic [IW-1:0] Q3 = IW'(3 * QUARTER);
  localparam logic [IW-1:0] Q4 = IW'(TABLE_SIZE);

  localparam logic signed [PROD_W-1:0] HALF_FRAC = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] HALF_AMP  = PROD_W'(64'd1 << 13);
  localparam logic signed [PROD_W-1:0] SAT_MAX   = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN   = -PROD_W'(32768);

  typedef logic [14:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k <= QUARTER; k++) begin
      tab[k] = quarter_sine(k, TW);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // input decode
  logic [3:0]  voice4_in;
  logic [VW-1:0] vaddr_in;
  logic        in_range;
  logic [31:0] wv_in;

  assign voice4_in = cfg.mono ? 4'd0 : in_data[3:0];
  assign vaddr_in  = VW'(voice4_in);
  assign in_range  = int'(voice4_in) < VOICES;
  assign wv_in     = in_data[83:52];

  always_comb begin
    status.out_free = !out_valid || out_ready;
    status.kind     = KIND_NONE;
    if (in_range) begin
      unique case (in_user)
        OP_TICK:    status.kind = KIND_TICK;
        OP_SET_INC: status.kind = KIND_SET_INC;
        OP_SET_AMP: status.kind = KIND_SET_AMP;
        default:    status.kind = KIND_NONE;
      endcase
    end
  end

  // latched item
  logic [VW-1:0]      voice_q;
  logic [3:0]         voice4_q;
  logic signed [31:0] fm_q;
  logic signed [15:0] am_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      voice_q  <= vaddr_in;
      voice4_q <= voice4_in;
      fm_q     <= signed'(in_data[35:4]);
      am_q     <= signed'(in_data[51:36]);
    end
  end

  // voice stores with valid bits standing in for reset values
  logic [VW-1:0]     rd_addr;
  logic              inc_we;
  logic              amp_we;
  logic              ph_we;
  logic [PW-1:0]     ph_wdata;
  logic [PW-1:0]     ph_rdata;
  logic [31:0]       inc_rdata;
  logic [15:0]       amp_rdata;
  logic [VOICES-1:0] ph_valid;
  logic [VOICES-1:0] inc_valid;
  logic [VOICES-1:0] amp_valid;
  logic              ph_valid_rd;
  logic              inc_valid_rd;
  logic              amp_valid_rd;

  assign rd_addr = ctl.load ? vaddr_in : voice_q;
  assign inc_we  = ctl.load && status.kind == KIND_SET_INC;
  assign amp_we  = ctl.load && status.kind == KIND_SET_AMP;
  assign ph_we   = ctl.out_load;

  pwso_ram #(.WIDTH(PW), .DEPTH(VOICES)) u_ph_ram (
    .clk   (clk),
    .we    (ph_we),
    .waddr (voice_q),
    .wdata (ph_wdata),
    .raddr (rd_addr),
    .rdata (ph_rdata)
  );

  pwso_ram #(.WIDTH(32), .DEPTH(VOICES)) u_inc_ram (
    .clk   (clk),
    .we    (inc_we),
    .waddr (vaddr_in),
    .wdata (wv_in),
    .raddr (rd_addr),
    .rdata (inc_rdata)
  );

  pwso_ram #(.WIDTH(16), .DEPTH(VOICES)) u_amp_ram (
    .clk   (clk),
    .we    (amp_we),
    .waddr (vaddr_in),
    .wdata (wv_in[15:0]),
    .raddr (rd_addr),
    .rdata (amp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_valid  <= '0;
      inc_valid <= '0;
      amp_valid <= '0;
    end else begin
      if (ph_we) begin
        ph_valid[voice_q] <= 1'b1;
      end
      if (inc_we) begin
        inc_valid[vaddr_in] <= 1'b1;
      end
      if (amp_we) begin
        amp_valid[vaddr_in] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ph_valid_rd  <= ph_valid[rd_addr];
    inc_valid_rd <= inc_valid[rd_addr];
    amp_valid_rd <= amp_valid[rd_addr];
  end

  // lookup position and effective amplitude
  logic [PW-1:0]      phase_rd;
  logic [PW-1:0]      fm_add;
  logic signed [15:0] amp_rd;
  logic signed [16:0] am_sum;
  logic signed [15:0] amp_eff;
  logic [PW-1:0]      pos_q;
  logic [31:0]        inc_q;
  logic signed [15:0] amp_q;

  assign phase_rd = ph_valid_rd ? ph_rdata : '0;
  assign fm_add   = cfg.fm_enable ? PW'(fm_q) : '0;
  assign amp_rd   = amp_valid_rd ? signed'(amp_rdata) : AMP_RESET;
  assign am_sum   = {amp_rd[15], amp_rd} + {am_q[15], am_q};

  always_comb begin
    amp_eff = amp_rd;
    if (cfg.am_enable) begin
      if (am_sum[16] != am_sum[15]) begin
        amp_eff = am_sum[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
        amp_eff = am_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pos_en) begin
      pos_q <= phase_rd + fm_add;
      inc_q <= inc_valid_rd ? inc_rdata : INC_RESET;
      amp_q <= amp_eff;
    end
  end

  assign ph_wdata = pos_q + PW'(inc_q);

  // table index folded onto the quarter wave
  logic [IW-1:0]  tab_idx;
  logic [IW-1:0]  q_idx;
  logic           q_neg;
  logic [QAW-1:0] q_addr;
  logic [14:0]    rom_q;
  logic           neg_q;

  assign tab_idx = {1'b0, pos_q[PW-1:FRAC_BITS]} + IW'(ctl.rom_sel);
  assign q_addr  = q_idx[QAW-1:0];

  always_comb begin
    if (tab_idx <= Q1) begin
      q_idx = tab_idx;
      q_neg = 1'b0;
    end else if (tab_idx <= Q2) begin
      q_idx = Q2 - tab_idx;
      q_neg = 1'b0;
    end else if (tab_idx <= Q3) begin
      q_idx = tab_idx - Q2;
      q_neg = 1'b1;
    end else begin
      q_idx = Q4 - tab_idx;
      q_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rom_en) begin
      rom_q <= QTAB[q_addr];
      neg_q <= q_neg;
    end
  end

  // interpolation and gain on one shared multiplier
  logic signed [15:0]        tab_val;
  logic signed [15:0]        t0_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [15:0]        interp_q;
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  frac_rnd;
  logic signed [16:0]        interp_sum;
  logic signed [PROD_W-1:0]  gain_rnd;
  logic signed [15:0]        sample_sat;

  assign tab_val = neg_q ? -signed'({1'b0, rom_q}) : signed'({1'b0, rom_q});

  always_ff @(posedge clk) begin
    if (ctl.cap_t0) begin
      t0_q <= tab_val;
    end
    if (ctl.cap_diff) begin
      diff_q <= {tab_val[15], tab_val} - {t0_q[15], t0_q};
    end
  end

  assign mul_a = ctl.mul_sel ? {interp_q[15], interp_q} : diff_q;
  assign mul_b = ctl.mul_sel ? MB_W'(amp_q) : signed'({1'b0, pos_q[FRAC_BITS-1:0]});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  assign frac_rnd   = (prod_q + HALF_FRAC) >>> FRAC_BITS;
  assign interp_sum = {t0_q[15], t0_q} + frac_rnd[16:0];

  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      interp_q <= interp_sum[15:0];
    end
  end

  assign gain_rnd = (prod_q + HALF_AMP) >>> 14;

  always_comb begin
    if (gain_rnd > SAT_MAX) begin
      sample_sat = 16'sh7fff;
    end else if (gain_rnd < SAT_MIN) begin
      sample_sat = 16'sh8000;
    end else begin
      sample_sat = gain_rnd[15:0];
    end
  end

  // output register
  logic [15:0] out_sample;
  logic [3:0]  out_voice;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_sample <= sample_sat;
      out_voice  <= voice4_q;
    end
  end

  assign out_data = {4'd0, out_voice, out_sample};

endmodule
